[rtl/sdwt_pkg.sv]
// Shared types and constants for the settle detector with timeout.
package sdwt_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned ERR_W   = 32;
    localparam int unsigned ELIM_W  = 31;
    localparam int unsigned CIDX_W  = 4;
    localparam int unsigned CDATA_W = 32;

    localparam logic [STAMP_W-1:0] TIMEOUT_RST = 32'd10000000;
    localparam logic [ELIM_W-1:0]  ELIM_RST    = 31'h7FFF_FFFF;
    localparam logic [ERR_W-1:0]   SLIM_RST    = 32'hFFFF_FFFF;
    localparam logic [STAMP_W-1:0] DWELL_RST   = 32'd0;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TIMEOUT = 4'd0,
        CFG_ELIMIT  = 4'd1,
        CFG_SLIMIT  = 4'd2,
        CFG_DWELL   = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [STAMP_W-1:0] timeout_ms;
        logic [ELIM_W-1:0]  error_limit;
        logic [ERR_W-1:0]   slope_limit;
        logic [STAMP_W-1:0] dwell_ms;
    } t_cfg;

endpackage

[rtl/settle_detector_with_timeout.sv]
// Settle detector with timeout: top level with request and result registers.
// A request accepted into the request register is evaluated into the result register
// when it fires (o_valid high after it), and its result can be taken from there.
// Throughput: one request per cycle unless stalled; the in-band and slope tests are
// one 33-bit subtract, magnitude and compare between the request and result registers.
// Stall on the input only while a request is held and the result register is stalled.
// Reset (synchronous, active low) empties both registers, forgets the start, entry and
// previous-error latches, and returns the configuration registers to their defaults.
module settle_detector_with_timeout (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sdwt_pkg::STAMP_W-1:0]  i_now_ms,
    input  logic [sdwt_pkg::ERR_W-1:0]    i_loop_error,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_settled,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sdwt_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [sdwt_pkg::CDATA_W-1:0]  i_cfg_data
);
    import sdwt_pkg::*;

    // request register
    logic               r_req_valid;
    logic [STAMP_W-1:0] r_now_ms;
    logic [ERR_W-1:0]   r_loop_error;
    // result register
    logic               r_out_valid;
    logic               r_settled;

    t_cfg cfg;
    logic out_free;   // result register can take a new value this cycle
    logic fire;       // held request moves into the result register
    logic take;       // new request captured
    logic n_settled;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_req_valid && out_free;
    assign take     = i_valid && (!r_req_valid || out_free);

    assign o_stall     = r_req_valid && !out_free;
    assign o_valid     = r_out_valid;
    assign o_settled   = r_settled;
    assign o_cfg_ready = 1'b1;   // registers always writable

    sdwt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // state advances only on the cycle a request moves to the result register,
    // so the next request always sees the state this one leaves
    sdwt_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_now_ms     (r_now_ms),
        .i_loop_error (r_loop_error),
        .i_cfg        (cfg),
        .o_settled    (n_settled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_req_valid <= 1'b1;
            end else if (fire) begin
                r_req_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_now_ms     <= i_now_ms;
            r_loop_error <= i_loop_error;
        end
        if (fire) begin
            r_settled <= n_settled;
        end
    end

endmodule

[rtl/sdwt_cfg.sv]
// Configuration register file for the settle detector.
module sdwt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sdwt_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [sdwt_pkg::CDATA_W-1:0]  i_cfg_data,
    output sdwt_pkg::t_cfg                o_cfg
);
    import sdwt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms  <= TIMEOUT_RST;
            r_cfg.error_limit <= ELIM_RST;
            r_cfg.slope_limit <= SLIM_RST;
            r_cfg.dwell_ms    <= DWELL_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT: r_cfg.timeout_ms  <= i_cfg_data[STAMP_W-1:0];
                CFG_ELIMIT:  r_cfg.error_limit <= i_cfg_data[ELIM_W-1:0];
                CFG_SLIMIT:  r_cfg.slope_limit <= i_cfg_data[ERR_W-1:0];
                CFG_DWELL:   r_cfg.dwell_ms    <= i_cfg_data[STAMP_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/sdwt_eval.sv]
// Per-request settle evaluation and the tracking state it updates.
module sdwt_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [sdwt_pkg::STAMP_W-1:0]  i_now_ms,
    input  logic [sdwt_pkg::ERR_W-1:0]    i_loop_error,
    input  sdwt_pkg::t_cfg                i_cfg,
    output logic                          o_settled
);
    import sdwt_pkg::*;

    logic [STAMP_W-1:0] r_start;
    logic               r_start_known;
    logic [STAMP_W-1:0] r_entry;
    logic               r_entry_known;
    logic [ERR_W-1:0]   r_last;
    logic               r_last_known;

    logic [STAMP_W-1:0] start_eff;
    logic [STAMP_W-1:0] entry_eff;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] dwelled;
    logic               timed_out;
    logic [ERR_W:0]     deriv;
    logic [ERR_W:0]     deriv_mag;
    logic [ERR_W-1:0]   err_mag;
    logic               slope_ok;
    logic               err_ok;
    logic               in_band;

    always_comb begin
        start_eff = r_start_known ? r_start : i_now_ms;
        elapsed   = i_now_ms - start_eff;
        timed_out = elapsed >= i_cfg.timeout_ms;

        // 33-bit difference never overflows
        deriv     = {i_loop_error[ERR_W-1], i_loop_error} - {r_last[ERR_W-1], r_last};
        deriv_mag = deriv[ERR_W] ? (~deriv + 1'b1) : deriv;
        slope_ok  = r_last_known && (deriv_mag <= {1'b0, i_cfg.slope_limit});

        // most negative error gives 2^31, above any 31-bit limit
        err_mag   = i_loop_error[ERR_W-1] ? (~i_loop_error + 1'b1) : i_loop_error;
        err_ok    = err_mag <= {1'b0, i_cfg.error_limit};
        in_band   = slope_ok && err_ok;

        entry_eff = r_entry_known ? r_entry : i_now_ms;
        dwelled   = i_now_ms - entry_eff;
        o_settled = timed_out || (in_band && (dwelled >= i_cfg.dwell_ms));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_known <= 1'b0;
            r_entry_known <= 1'b0;
            r_last_known  <= 1'b0;
        end else if (i_fire) begin
            r_start_known <= 1'b1;
            if (!timed_out) begin
                r_last_known  <= 1'b1;
                r_entry_known <= in_band;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_start <= start_eff;
            if (!timed_out) begin
                r_last  <= i_loop_error;
                r_entry <= entry_eff;
            end
        end
    end

endmodule

[rtl/sdwt_checker.sv]
// Port-level checks for the settle detector, bound to the top level.
module sdwt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_settled,
    input logic o_cfg_ready
);

    // held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_settled)))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input back-pressure only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // a result that is taken with nothing pending leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_stall && !i_valid && $past(!i_valid) && $past(!o_valid))
        |=> !o_valid)
        else $error("result appeared with no request");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind settle_detector_with_timeout sdwt_checker u_sdwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_settled   (o_settled),
    .o_cfg_ready (o_cfg_ready)
);

[test/settle_detector_with_timeout_tb.sv]
// Self-checking testbench for the settle detector with timeout.
module settle_detector_with_timeout_tb;

    import sdwt_pkg::*;

    // Q2.30 scale used for the largest settling transients
    localparam int unsigned BIG_AMP = 1 << 30;

    typedef struct packed {
        logic [STAMP_W-1:0] now_ms;
        logic [ERR_W-1:0]   loop_error;
    } t_sample;

    // DUT ports; the inputs are all known from time zero
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic [STAMP_W-1:0] i_now_ms     = '0;
    logic [ERR_W-1:0]   i_loop_error = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic               o_settled;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index  = '0;
    logic [CDATA_W-1:0] i_cfg_data   = '0;

    // requests waiting to be driven, and settled flags waiting to come back
    t_sample sample_q[$];
    logic    settled_exp_q[$];
    int      fail_count = 0;
    int      gen_count  = 0;

    // our copy of the detector: configuration and latches
    t_cfg               cfg_model = '{timeout_ms: TIMEOUT_RST, error_limit: ELIM_RST,
                                      slope_limit: SLIM_RST, dwell_ms: DWELL_RST};
    logic [STAMP_W-1:0] start_stamp = '0;
    logic               start_known = 1'b0;
    logic [STAMP_W-1:0] entry_stamp = '0;
    logic               entry_known = 1'b0;
    logic [ERR_W-1:0]   last_err    = '0;
    logic               last_known  = 1'b0;

    // request side pacing
    t_sample     cur_sample;
    logic        drv_busy   = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic [15:0] stall_cyc  = '0;
    logic        mon_exp;

    // base stamp: most generated times are offsets from the first request's time,
    // so for those the elapsed time seen by the timeout check is just the offset
    logic [STAMP_W-1:0] t0_ms = 32'hFFFF_FFF0;

    settle_detector_with_timeout i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_ms     (i_now_ms),
        .i_loop_error (i_loop_error),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_settled    (o_settled),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Settled flag for one accepted request; advances the latches.
    function automatic logic predict_settled(input logic [STAMP_W-1:0] now,
                                             input logic [ERR_W-1:0] err);
        logic [STAMP_W-1:0] elapsed;
        logic [ERR_W:0]     slope;
        logic [ERR_W:0]     slope_mag;
        logic [ERR_W-1:0]   err_mag;
        logic               slope_ok;
        if (!start_known) begin
            start_stamp = now;
            start_known = 1'b1;
        end
        elapsed = now - start_stamp;
        // timeout: nothing but the start latch moves
        if (elapsed >= cfg_model.timeout_ms) return 1'b1;
        // 33-bit slope; with no previous error it is out of band
        if (last_known) begin
            slope     = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};
            slope_mag = slope[ERR_W] ? -slope : slope;
            slope_ok  = slope_mag <= {1'b0, cfg_model.slope_limit};
        end else begin
            slope_ok = 1'b0;
        end
        last_err   = err;
        last_known = 1'b1;
        // most negative error has magnitude 2^31, above any limit
        err_mag = err[ERR_W-1] ? -err : err;
        if (slope_ok && err_mag <= {1'b0, cfg_model.error_limit}) begin
            if (!entry_known) begin
                entry_stamp = now;
                entry_known = 1'b1;
            end
            elapsed = now - entry_stamp;
            return elapsed >= cfg_model.dwell_ms;
        end
        entry_known = 1'b0;
        entry_stamp = '0;
        return 1'b0;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            drv_busy = 1'b0;
        end else begin
            if (drv_busy && !o_stall) begin
                settled_exp_q.push_back(predict_settled(cur_sample.now_ms,
                                                        cur_sample.loop_error));
                drv_busy = 1'b0;
            end
            if (!drv_busy && sample_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    cur_sample = sample_q.pop_front();
                    drv_busy   = 1'b1;
                    i_now_ms     <= cur_sample.now_ms;
                    i_loop_error <= cur_sample.loop_error;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        // a quarter of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
            // held high while stalled, so the payload stays put too
            i_valid <= drv_busy;
        end
    end

    // Result stall pattern: free, random, periodic and long stalls in turn.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_cyc <= stall_cyc + 16'd1;
            case (stall_cyc[8:7])
                2'd0: i_stall <= 1'b0;
                2'd1: i_stall <= ($urandom_range(0, 2) == 0);
                2'd2: i_stall <= (stall_cyc[1:0] == 2'd0);
                default: i_stall <= (stall_cyc[3:0] < 4'd11);
            endcase
        end
    end

    // Result monitor: in-order compare against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (settled_exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual settled=%0b",
                         $time, o_settled);
                fail_count++;
            end else begin
                mon_exp = settled_exp_q.pop_front();
                if (o_settled !== mon_exp) begin
                    $display("%0t: settled mismatch, expected %0b, actual %0b",
                             $time, mon_exp, o_settled);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_sample(input logic [STAMP_W-1:0] now, input logic [ERR_W-1:0] err);
        t_sample s;
        s.now_ms     = now;
        s.loop_error = err;
        sample_q.push_back(s);
        gen_count++;
    endtask

    // Register write; the model follows at the accepting edge.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TIMEOUT: cfg_model.timeout_ms  = data;
            CFG_ELIMIT:  cfg_model.error_limit = data[ELIM_W-1:0];
            CFG_SLIMIT:  cfg_model.slope_limit = data;
            CFG_DWELL:   cfg_model.dwell_ms    = data;
            default: ;  // unmapped index, dropped
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Block until every request is driven and every result checked.
    task automatic wait_drained();
        while (sample_q.size() != 0 || drv_busy || settled_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // A loop settling toward zero: small time steps, decaying error with
    // noise, and the odd spike that throws it out of band.
    task automatic add_settle_run(input logic [STAMP_W-1:0] span);
        logic [STAMP_W-1:0] off;
        int                 amp;
        int                 nz;
        int                 e;
        int                 len;
        int                 k;
        bit                 neg;
        off = $urandom_range(0, span);
        case ($urandom_range(0, 5))
            0:       amp = 0;
            1:       amp = $urandom_range(0, BIG_AMP);
            default: amp = $urandom_range(0, 1 << 24);
        endcase
        nz  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1 << 10);
        neg = $urandom_range(0, 1);
        len = $urandom_range(6, 40);
        for (k = 0; k < len; k++) begin
            e = amp >> k;
            if (neg) e = -e;
            if (nz != 0) e = e + int'($urandom_range(0, 2 * nz)) - nz;
            if ($urandom_range(0, 15) == 0) e = $urandom();
            push_sample(t0_ms + off, e);
            off = off + $urandom_range(0, 4);
        end
    endtask

    initial begin : stimulus
        int               ph;
        int               target;
        logic [STAMP_W-1:0] span;
        int               k;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // -- directed, reset configuration; start latched just below the wrap
        push_sample(t0_ms, 32'd0);                       // first slope: out of band
        push_sample(t0_ms + 32'd1, 32'd0);               // in band, zero dwell
        push_sample(t0_ms + 32'd2, 32'h8000_0000);       // most negative error
        push_sample(t0_ms + 32'd3, 32'h7FFF_FFFF);       // largest slope, still in band
        push_sample(t0_ms + 32'd4, 32'h8000_0000);
        push_sample(t0_ms + 32'd5, 32'hFFFF_FFFF);
        push_sample(t0_ms + 32'd20, 32'd0);              // time counter wrapped
        push_sample(t0_ms + TIMEOUT_RST, 32'h8000_0000); // timeout exactly reached
        push_sample(t0_ms + TIMEOUT_RST - 32'd1, 32'd0); // one short of timeout
        push_sample(t0_ms + 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        wait_drained();

        // -- directed: dwell across the time wrap, errors at the band edges
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_ELIMIT, 32'd1 << 16);
        write_reg(CFG_SLIMIT, 32'd1 << 16);
        write_reg(CFG_DWELL, 32'd8);
        for (k = 0; k < 10; k++) push_sample(t0_ms + 3 * k, 32'd0);
        push_sample(t0_ms + 32'd30, 32'd1 << 16);        // error and slope at limit
        push_sample(t0_ms + 32'd31, -(32'sd1 << 16));    // slope over limit
        push_sample(t0_ms + 32'd32, -(32'sd1 << 16));
        push_sample(t0_ms + 32'd33, -(32'sd1 << 16) - 1); // error one over limit
        wait_drained();

        // -- random phases, each under its own settings
        for (ph = 2; ph <= 8; ph++) begin
            case (ph)
                2: begin
                    // zero timeout: everything reports settled
                    write_reg(CFG_TIMEOUT, 32'd0);
                    write_reg(CFG_ELIMIT, 32'd0);
                    write_reg(CFG_SLIMIT, 32'd0);
                    write_reg(CFG_DWELL, 32'hFFFF_FFFF);
                    write_reg(4'(CFG_DWELL) + 4'($urandom_range(1, 12)), $urandom());
                    span   = 32'hFFFF_FFFF;
                    target = 60;
                end
                3: begin
                    // zero-width band: only a constant zero error is in band
                    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(CFG_DWELL, 32'd0);
                    span   = 32'hFFFF_FFFF;
                    target = 215;
                end
                4: begin
                    // widest band with the longest dwell; times straddle the timeout
                    write_reg(CFG_TIMEOUT, 32'd5000);
                    write_reg(CFG_ELIMIT, 32'hFFFF_FFFF);
                    write_reg(CFG_SLIMIT, 32'hFFFF_FFFF);
                    write_reg(CFG_DWELL, 32'hFFFF_FFFF);
                    span   = 32'd8000;
                    target = 215;
                end
                default: begin
                    write_reg(CFG_TIMEOUT, ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                                      : $urandom_range(1000, 1 << 20));
                    write_reg(CFG_ELIMIT, $urandom_range(1 << 12, 1 << 20));
                    write_reg(CFG_SLIMIT, $urandom_range(1 << 12, 1 << 20));
                    write_reg(CFG_DWELL, $urandom_range(0, 50));
                    write_reg(4'(CFG_DWELL) + 4'($urandom_range(1, 12)), $urandom());
                    span = (cfg_model.timeout_ms == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                         : cfg_model.timeout_ms + (cfg_model.timeout_ms >> 2);
                    target = 215;
                end
            endcase
            gen_count = 0;
            while (gen_count < target) begin
                case ($urandom_range(0, 9))
                    0:       push_sample($urandom(), $urandom());
                    1:       push_sample(t0_ms + $urandom_range(0, span), $urandom());
                    default: add_settle_run(span);
                endcase
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (settled_exp_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, settled_exp_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/sdwt_pkg.sv
rtl/sdwt_cfg.sv
rtl/sdwt_eval.sv
rtl/settle_detector_with_timeout.sv
rtl/sdwt_checker.sv
test/settle_detector_with_timeout_tb.sv
